// ===== sv/sskc_pkg.sv =====
package sskc_pkg;

  localparam int SCAN_ROWS = 3;
  localparam int ADC_BITS  = 12;

  localparam int ROW_W  = $clog2(SCAN_ROWS);
  localparam int OP_W   = 2;
  localparam int MEAS_W = 10;
  localparam int SP_W   = 10;
  localparam int THR_W  = 6;
  localparam int SEG_W  = 8;
  localparam int STEP_W = 2;

  // Converter arithmetic is wide enough for the sample and for the clamp limit
  localparam int ADC_CALC_W = (ADC_BITS > 13) ? ADC_BITS - 2 : 11;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_THRESHOLD     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_POWER_ON_SETPOINT = CFG_INDEX_W'(1);

  localparam logic [OP_W-1:0] OP_ZERO_CROSS = 2'd0;
  localparam logic [OP_W-1:0] OP_SCAN       = 2'd1;
  localparam logic [OP_W-1:0] OP_HALF_SEC   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE       = 2'd3;

  localparam logic [ROW_W-1:0] ROW_PLUS  = ROW_W'(0);
  localparam logic [ROW_W-1:0] ROW_MINUS = ROW_W'(1);
  localparam logic [ROW_W-1:0] ROW_STAR  = ROW_W'(2);

  localparam logic [STEP_W-1:0] EDIT_IDLE     = 2'd0;
  localparam logic [STEP_W-1:0] EDIT_HUNDREDS = 2'd1;
  localparam logic [STEP_W-1:0] EDIT_TENS     = 2'd2;
  localparam logic [STEP_W-1:0] EDIT_UNITS    = 2'd3;

  localparam logic [THR_W-1:0] THR_RESET   = THR_W'(60);
  localparam logic [SP_W-1:0]  SP_MAX      = SP_W'(999);
  localparam logic [SP_W-1:0]  SP_RANGE    = SP_W'(1000);
  localparam logic [SP_W-1:0]  SHOW_SE     = SP_W'(511);
  localparam int               MEAS_OFFSET = 20;
  localparam int               MEAS_LIMIT  = 511;

  localparam logic [SEG_W-1:0] SEG_S    = 8'hb6;
  localparam logic [SEG_W-1:0] SEG_DASH = 8'h02;
  localparam logic [SEG_W-1:0] SEG_E    = 8'h9e;

  localparam int IN_DATA_W    = ((ADC_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + ROW_W + SEG_W + SP_W + MEAS_W + STEP_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_SP_LSB   = 1 + ROW_W + SEG_W;
  localparam int OUT_STEP_LSB = OUT_SP_LSB + SP_W + MEAS_W;
  localparam int OUT_SAVE_BIT = OUT_STEP_LSB + STEP_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                     is_zc;
    logic                     is_scan;
    logic                     is_half;
    logic                     key_level;
    logic signed [MEAS_W-1:0] meas;
  } evt_t;

  function automatic logic [SEG_W-1:0] digit_font(input logic [3:0] d);
    logic [SEG_W-1:0] f;
    case (d)
      4'd0:    f = 8'hfc;
      4'd1:    f = 8'h60;
      4'd2:    f = 8'hda;
      4'd3:    f = 8'hf2;
      4'd4:    f = 8'h66;
      4'd5:    f = 8'hb6;
      4'd6:    f = 8'hbe;
      4'd7:    f = 8'he0;
      4'd8:    f = 8'hfe;
      4'd9:    f = 8'hf6;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

  // Pattern of one display digit; row 0 is units, row 2 hundreds. v is 0..999.
  function automatic logic [SEG_W-1:0] display_byte(input logic [SP_W-1:0] v,
                                                   input logic [ROW_W-1:0] row);
    logic [17:0]     p1;
    logic [6:0]      t;
    logic [SP_W-1:0] u_full;
    logic [14:0]     p2;
    logic [3:0]      h;
    logic [6:0]      tn_full;
    logic [3:0]      d;
    logic [SEG_W-1:0] b;
    // multiply by 205 then shift by 11 divides by ten below 1029
    p1      = 18'(v) * 18'd205;
    t       = p1[17:11];
    u_full  = v - SP_W'(t) * SP_W'(10);
    p2      = 15'(t) * 15'd205;
    h       = p2[14:11];
    tn_full = t - 7'(h) * 7'd10;
    unique case (row)
      ROW_PLUS:  d = u_full[3:0];
      ROW_MINUS: d = tn_full[3:0];
      default:   d = h;
    endcase
    if (v == SHOW_SE) begin
      unique case (row)
        ROW_PLUS:  b = SEG_E;
        ROW_MINUS: b = SEG_DASH;
        default:   b = SEG_S;
      endcase
    end else begin
      b = digit_font(d);
    end
    return b;
  endfunction

endpackage

// ===== sv/sskc_front.sv =====
module sskc_front
  import sskc_pkg::*;
(
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [OP_W-1:0]      s_tuser,
  output logic                 push_valid,
  input  logic                 push_ready,
  output evt_t                 push_evt
);

  logic [ADC_BITS-1:0]   adc;
  logic [ADC_CALC_W-1:0] shifted;
  logic [ADC_CALC_W-1:0] diff;

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign adc        = s_tdata[ADC_BITS-1:0];

  always_comb begin
    shifted = ADC_CALC_W'(adc >> 3);
    diff    = shifted - ADC_CALC_W'(MEAS_OFFSET);

    push_evt           = '0;
    push_evt.key_level = s_tdata[ADC_BITS];
    // clamp wide converters at the display limit
    if (shifted > ADC_CALC_W'(MEAS_LIMIT + MEAS_OFFSET)) begin
      push_evt.meas = MEAS_W'(MEAS_LIMIT);
    end else begin
      push_evt.meas = MEAS_W'(diff);
    end

    unique case (s_tuser)
      OP_ZERO_CROSS: push_evt.is_zc   = 1'b1;
      OP_SCAN:       push_evt.is_scan = 1'b1;
      OP_HALF_SEC:   push_evt.is_half = 1'b1;
      OP_NONE:       push_evt.is_zc   = 1'b0;
      default:       push_evt.is_zc   = 1'b0;
    endcase
  end

endmodule

// ===== sv/sskc_queue.sv =====
module sskc_queue
  import sskc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  evt_t push_evt,
  output logic pop_valid,
  input  logic pop_ready,
  output evt_t pop_evt
);

  evt_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_evt    = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + QCNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_evt;
    end
  end

endmodule

// ===== sv/sskc_back.sv =====
module sskc_back
  import sskc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   evt_valid,
  output logic                   evt_ready,
  input  evt_t                   evt,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata
);

  // Display buffer kept as shown value, blanked digits and decimal point
  logic [THR_W-1:0]         thr;
  logic [SP_W-1:0]          setpoint;
  logic signed [MEAS_W-1:0] measured;
  logic                     heater;
  logic                     kc_pressed [SCAN_ROWS];
  logic                     kc_handled [SCAN_ROWS];
  logic [THR_W-1:0]         kc_count   [SCAN_ROWS];
  logic [ROW_W-1:0]         row_idx;
  logic [STEP_W-1:0]        edit_step;
  logic [SP_W-1:0]          edit_value;
  logic                     blink;
  logic [SP_W-1:0]          disp_value;
  logic [SCAN_ROWS-1:0]     disp_blank;
  logic                     disp_dp;

  logic [SP_W-1:0]          setpoint_next;
  logic signed [MEAS_W-1:0] measured_next;
  logic                     heater_next;
  logic                     kc_pressed_next [SCAN_ROWS];
  logic                     kc_handled_next [SCAN_ROWS];
  logic [THR_W-1:0]         kc_count_next   [SCAN_ROWS];
  logic [ROW_W-1:0]         row_idx_next;
  logic [STEP_W-1:0]        edit_step_next;
  logic [SP_W-1:0]          edit_value_next;
  logic                     blink_next;
  logic [SP_W-1:0]          disp_value_next;
  logic [SCAN_ROWS-1:0]     disp_blank_next;
  logic                     disp_dp_next;

  logic                     fire;
  logic                     cfg_fire;
  logic [ROW_W-1:0]         row;
  logic [THR_W-1:0]         thr_eff;
  logic [SEG_W-1:0]         cur_byte;
  logic [SEG_W-1:0]         drive;
  logic [ROW_W-1:0]         row_out;
  logic                     sub_tick;
  logic                     save;
  logic                     up_hit;
  logic                     down_hit;
  logic [SP_W-1:0]          sp_up;
  logic [SP_W-1:0]          step_val;
  logic [SP_W-1:0]          upper;
  logic [ROW_W-1:0]         blank_row;
  logic [SP_W-1:0]          cfg_sp;

  assign evt_ready = !m_tvalid || m_tready;
  assign fire      = evt_valid && evt_ready;
  // hold register writes off while a request is queued or a result waits
  assign cfg_ready = !evt_valid && !m_tvalid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_sp    = (cfg_data > SP_MAX) ? SP_MAX : cfg_data;

  assign row       = (row_idx >= ROW_W'(SCAN_ROWS)) ? ROW_PLUS : row_idx;
  assign thr_eff   = (thr == '0) ? THR_W'(1) : thr;
  assign blank_row = ROW_W'(SCAN_ROWS) - edit_step;

  always_comb begin
    cur_byte = disp_blank[row] ? '0 : display_byte(disp_value, row);
    if (row == ROW_PLUS) begin
      cur_byte[0] = cur_byte[0] | disp_dp;
    end
  end

  always_comb begin
    setpoint_next   = setpoint;
    measured_next   = measured;
    heater_next     = heater;
    kc_pressed_next = kc_pressed;
    kc_handled_next = kc_handled;
    kc_count_next   = kc_count;
    row_idx_next    = row_idx;
    edit_step_next  = edit_step;
    edit_value_next = edit_value;
    blink_next      = blink;
    disp_value_next = disp_value;
    disp_blank_next = disp_blank;
    disp_dp_next    = disp_dp;
    drive           = '0;
    row_out         = ROW_PLUS;
    sub_tick        = 1'b0;
    save            = 1'b0;

    // event stage
    if (evt.is_zc) begin
      measured_next = evt.meas;
      heater_next   = !($signed({evt.meas[MEAS_W-1], evt.meas}) >
                        $signed({1'b0, setpoint}));
      disp_dp_next  = heater_next;
    end
    if (evt.is_scan) begin
      row_out = row;
      drive   = ~cur_byte;
      for (int i = 0; i < SCAN_ROWS; i++) begin
        if (ROW_W'(i) == row) begin
          if (evt.key_level) begin
            kc_pressed_next[i] = 1'b1;
            if (kc_count[i] < thr_eff) begin
              kc_count_next[i] = kc_count[i] + THR_W'(1);
            end
          end else begin
            kc_pressed_next[i] = 1'b0;
            kc_handled_next[i] = 1'b0;
            kc_count_next[i]   = '0;
          end
        end
      end
      if (row == ROW_W'(SCAN_ROWS - 1)) begin
        row_idx_next = ROW_PLUS;
        sub_tick     = 1'b1;
      end else begin
        row_idx_next = row + ROW_W'(1);
      end
    end

    // half-second tick: show the measured value when idle, else blink the edited digit
    if (evt.is_half) begin
      if (edit_step == EDIT_IDLE) begin
        disp_value_next = measured[MEAS_W-1] ? '0 : SP_W'(measured);
        disp_blank_next = '0;
        disp_dp_next    = 1'b0;
      end else if (blink) begin
        disp_blank_next[blank_row] = 1'b1;
        if (blank_row == ROW_PLUS) begin
          disp_dp_next = 1'b0;
        end
      end else begin
        disp_value_next = edit_value;
        disp_blank_next = '0;
        disp_dp_next    = 1'b0;
      end
      blink_next = !blink;
    end

    // hold-to-repeat on plus and minus
    up_hit   = sub_tick && (kc_count_next[ROW_PLUS] == thr_eff);
    down_hit = sub_tick && (kc_count_next[ROW_MINUS] == thr_eff);
    sp_up    = (up_hit && setpoint < SP_MAX) ? setpoint + SP_W'(1) : setpoint;
    setpoint_next = (down_hit && sp_up != '0) ? sp_up - SP_W'(1) : sp_up;
    if (up_hit || down_hit) begin
      disp_value_next = setpoint_next;
      disp_blank_next = '0;
      disp_dp_next    = 1'b0;
    end

    // digit editor
    unique case (edit_step)
      EDIT_HUNDREDS: step_val = SP_W'(100);
      EDIT_TENS:     step_val = SP_W'(10);
      default:       step_val = SP_W'(1);
    endcase
    upper = (edit_step == EDIT_UNITS) ? SP_MAX : SP_RANGE - step_val;

    if (edit_step == EDIT_IDLE) begin
      if (kc_pressed_next[ROW_STAR] && !kc_handled_next[ROW_STAR]) begin
        edit_step_next            = EDIT_HUNDREDS;
        edit_value_next           = setpoint_next;
        disp_value_next           = setpoint_next;
        disp_blank_next           = '0;
        disp_dp_next              = 1'b0;
        kc_handled_next[ROW_STAR] = 1'b1;
      end
    end else if (kc_pressed_next[ROW_PLUS] && !kc_handled_next[ROW_PLUS]) begin
      if (edit_value < upper) begin
        edit_value_next = edit_value + step_val;
      end
      disp_value_next           = edit_value_next;
      disp_blank_next           = '0;
      disp_dp_next              = 1'b0;
      kc_handled_next[ROW_PLUS] = 1'b1;
    end else if (kc_pressed_next[ROW_MINUS] && !kc_handled_next[ROW_MINUS]) begin
      if (edit_value > step_val) begin
        edit_value_next = edit_value - step_val;
      end
      disp_value_next            = edit_value_next;
      disp_blank_next            = '0;
      disp_dp_next               = 1'b0;
      kc_handled_next[ROW_MINUS] = 1'b1;
    end else if (kc_pressed_next[ROW_STAR] && !kc_handled_next[ROW_STAR]) begin
      kc_handled_next[ROW_STAR] = 1'b1;
      if (edit_step == EDIT_UNITS) begin
        setpoint_next  = edit_value;
        edit_step_next = EDIT_IDLE;
        save           = 1'b1;
      end else begin
        edit_step_next  = edit_step + STEP_W'(1);
        disp_value_next = edit_value;
        disp_blank_next = '0;
        disp_dp_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= THR_RESET;
      setpoint   <= '0;
      measured   <= '0;
      heater     <= 1'b0;
      for (int i = 0; i < SCAN_ROWS; i++) begin
        kc_pressed[i] <= 1'b0;
        kc_handled[i] <= 1'b0;
        kc_count[i]   <= '0;
      end
      row_idx    <= '0;
      edit_step  <= EDIT_IDLE;
      edit_value <= '0;
      blink      <= 1'b0;
      disp_value <= '0;
      disp_blank <= '1;
      disp_dp    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_KEY_THRESHOLD:     thr      <= cfg_data[THR_W-1:0];
        CFG_POWER_ON_SETPOINT: setpoint <= cfg_sp;
        default:               thr      <= thr;
      endcase
    end else begin
      if (fire) begin
        setpoint   <= setpoint_next;
        measured   <= measured_next;
        heater     <= heater_next;
        kc_pressed <= kc_pressed_next;
        kc_handled <= kc_handled_next;
        kc_count   <= kc_count_next;
        row_idx    <= row_idx_next;
        edit_step  <= edit_step_next;
        edit_value <= edit_value_next;
        blink      <= blink_next;
        disp_value <= disp_value_next;
        disp_blank <= disp_blank_next;
        disp_dp    <= disp_dp_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= OUT_DATA_W'({save, edit_step_next, measured_next, setpoint_next,
                              drive, row_out, heater_next});
    end
  end

endmodule

// ===== sv/solder_station_keypad_setpoint_ctrl.sv =====
// Channel  Dir  Handshake            Content
// s        in   s_tvalid/s_tready    event request: op, converter sample, key line
// m        out  m_tvalid/m_tready    one result per event request
// cfg      in   cfg_valid/cfg_ready  register write: index and data
//
// Sustained rate is one request per clock while m_tready stays high; the back stage
// decodes each event combinationally and registers its result in m_tdata.
// Sync reset sets threshold 60, setpoint 0, blanks digits, clears other control state.
// A two-entry queue between front and back absorbs m_tready stalls; s_tready drops
// only when it is full.
// cfg_ready stays low while a request is queued or a result waits.
module solder_station_keypad_setpoint_ctrl
  import sskc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // adc_sample, key_level, zero fill
  input  logic [OP_W-1:0]        s_tuser,   // op
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // heater_on, scan_row, segment_drive, setpoint,
                                            // measured, edit_step, save_request, zero fill
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic push_valid;
  logic push_ready;
  evt_t push_evt;
  logic pop_valid;
  logic pop_ready;
  evt_t pop_evt;

  sskc_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_evt   (push_evt)
  );

  sskc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_evt   (push_evt),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_evt    (pop_evt)
  );

  sskc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (pop_valid),
    .evt_ready (pop_ready),
    .evt       (pop_evt),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef SYNTHESIS
  a_save_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_SAVE_BIT] |-> m_tdata[OUT_STEP_LSB +: STEP_W] == EDIT_IDLE)
    else $error("save strobe without return to idle");

  a_setpoint_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_SP_LSB +: SP_W] <= SP_MAX)
    else $error("setpoint out of range");

  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(pop_valid && pop_ready))
    else $error("result without a request");
`endif

endmodule
